// ===== rtl/core/binary_max_heap_queue_macros.svh =====
// Assertion macros used by the checker file of the heap queue.
// No dependencies; include by bare file name.
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// Check cons in the same cycle as ante.
`define BMHQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Package for the binary max-heap queue: widths, codes and the command and
// status structs between controller and datapath. No dependencies.
package bmhq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 11;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [2:0] rd_sel_t;

    localparam rd_sel_t RD_PARENT = 3'd0;
    localparam rd_sel_t RD_ROOT   = 3'd1;
    localparam rd_sel_t RD_LAST   = 3'd2;
    localparam rd_sel_t RD_LEFT   = 3'd3;
    localparam rd_sel_t RD_RIGHT  = 3'd4;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    take_root;
        logic    take_last;
        logic    take_left;
        logic    take_right;
        logic    move_up;
        logic    move_down;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic status_ok;
        logic pos_zero;
        logic count_zero;
        logic parent_zero;
        logic key_gt_rdata;
        logic lc_valid;
        logic rc_valid;
        logic right_gt_child;
        logic child_gt_key;
        logic slot_free;
    } sts_t;

endpackage

// ===== rtl/core/bmhq_in_if.sv =====
// Request channel of the heap queue: valid, ready and one operation item.
// Depends on bmhq_pkg.
interface bmhq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [bmhq_pkg::KEY_W-1:0]    value;

    modport source (output valid, opcode, value, input ready);
    modport sink   (input valid, opcode, value, output ready);
    modport mon    (input valid, opcode, value, ready);
endinterface

// ===== rtl/core/bmhq_out_if.sv =====
// Response channel of the heap queue: valid, ready and one result item.
// Depends on bmhq_pkg.
interface bmhq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bmhq_pkg::KEY_W-1:0]    max_value;
    logic [bmhq_pkg::STATUS_W-1:0]        status;
    logic [bmhq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, max_value, status, entry_count, input ready);
    modport sink   (input valid, max_value, status, entry_count, output ready);
    modport mon    (input valid, max_value, status, entry_count, ready);
endinterface

// ===== rtl/core/bmhq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bmhq_dp.sv =====
// Datapath of the heap queue: heap RAM, entry count, moving key, sift
// position, child candidate and the response register. Depends on bmhq_pkg, bmhq_ram.
module bmhq_dp #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bmhq_pkg::cmd_t                    ctl,
    output bmhq_pkg::sts_t                    sts,
    input  logic                              in_opcode,
    input  logic signed [bmhq_pkg::KEY_W-1:0] in_value,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [bmhq_pkg::KEY_W-1:0] out_max_value,
    output logic [bmhq_pkg::STATUS_W-1:0]     out_status,
    output logic [bmhq_pkg::COUNT_W-1:0]      out_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;
    localparam int KW = bmhq_pkg::KEY_W;

    logic                           op_reg;
    logic signed [KW-1:0]           key_reg;
    logic [bmhq_pkg::STATUS_W-1:0]  status_reg;
    logic                           wr_key_reg;
    logic [AW-1:0]                  pos_reg;
    logic [CW-1:0]                  count_reg;
    logic signed [KW-1:0]           result_reg;
    logic signed [KW-1:0]           child_reg;
    logic [AW-1:0]                  cidx_reg;
    logic                           out_valid_reg;
    logic signed [KW-1:0]           out_max_reg;
    logic [bmhq_pkg::STATUS_W-1:0]  out_status_reg;
    logic [bmhq_pkg::COUNT_W-1:0]   out_count_reg;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [KW-1:0]                  ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [KW-1:0]                  ram_rdata;

    logic                           cnt_full;
    logic                           cnt_zero;
    logic [AW-1:0]                  pos_m1;
    logic [AW-1:0]                  parent;
    logic [XW-1:0]                  lc_x;
    logic [XW-1:0]                  rc_x;
    logic [XW-1:0]                  cnt_x;
    logic                           slot_free;

    assign cnt_full  = (count_reg == CW'(CAPACITY));
    assign cnt_zero  = (count_reg == '0);
    assign pos_m1    = pos_reg - AW'(1);
    assign parent    = pos_m1 >> 1;
    assign lc_x      = XW'({pos_reg, 1'b1});
    assign rc_x      = lc_x + XW'(1);
    assign cnt_x     = XW'(count_reg);
    assign slot_free = !out_valid_reg || out_ready;

    // heap storage
    bmhq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = key_reg;
        if (ctl.move_up)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (ctl.move_down)
        begin
            ram_we    = 1'b1;
            ram_wdata = child_reg;
        end
        else if (ctl.finish && wr_key_reg)
        begin
            ram_we    = 1'b1;
        end
    end

    always_comb
    begin
        unique case (ctl.rd_sel)
            bmhq_pkg::RD_PARENT: ram_raddr = parent;
            bmhq_pkg::RD_ROOT:   ram_raddr = '0;
            bmhq_pkg::RD_LAST:   ram_raddr = AW'(count_reg);
            bmhq_pkg::RD_LEFT:   ram_raddr = lc_x[AW-1:0];
            bmhq_pkg::RD_RIGHT:  ram_raddr = rc_x[AW-1:0];
            default:             ram_raddr = '0;
        endcase
    end

    // control state: entry count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                if (in_opcode == bmhq_pkg::OP_INSERT)
                begin
                    if (!cnt_full)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                else if (!cnt_zero)
                begin
                    count_reg <= count_reg - CW'(1);
                end
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg     <= in_opcode;
            key_reg    <= in_value;
            result_reg <= '0;
            if (in_opcode == bmhq_pkg::OP_INSERT)
            begin
                status_reg <= cnt_full ? bmhq_pkg::ST_FULL : bmhq_pkg::ST_OK;
                wr_key_reg <= !cnt_full;
                pos_reg    <= AW'(count_reg);
            end
            else
            begin
                status_reg <= cnt_zero ? bmhq_pkg::ST_EMPTY : bmhq_pkg::ST_OK;
                wr_key_reg <= (count_reg > CW'(1));
                pos_reg    <= '0;
            end
        end
        if (ctl.take_root)
        begin
            result_reg <= $signed(ram_rdata);
        end
        if (ctl.take_last)
        begin
            key_reg <= $signed(ram_rdata);
        end
        if (ctl.take_left)
        begin
            child_reg <= $signed(ram_rdata);
            cidx_reg  <= lc_x[AW-1:0];
        end
        if (ctl.take_right)
        begin
            child_reg <= $signed(ram_rdata);
            cidx_reg  <= rc_x[AW-1:0];
        end
        if (ctl.move_up)
        begin
            pos_reg <= parent;
        end
        if (ctl.move_down)
        begin
            pos_reg <= cidx_reg;
        end
        if (ctl.finish)
        begin
            out_max_reg    <= result_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= bmhq_pkg::COUNT_W'(count_reg);
        end
    end

    always_comb
    begin
        sts.is_insert      = (op_reg == bmhq_pkg::OP_INSERT);
        sts.status_ok      = (status_reg == bmhq_pkg::ST_OK);
        sts.pos_zero       = (pos_reg == '0);
        sts.count_zero     = cnt_zero;
        sts.parent_zero    = (parent == '0);
        sts.key_gt_rdata   = (key_reg > $signed(ram_rdata));
        sts.lc_valid       = (lc_x < cnt_x);
        sts.rc_valid       = (rc_x < cnt_x);
        sts.right_gt_child = ($signed(ram_rdata) > child_reg);
        sts.child_gt_key   = (child_reg > key_reg);
        sts.slot_free      = slot_free;
    end

    assign out_valid       = out_valid_reg;
    assign out_max_value   = out_max_reg;
    assign out_status      = out_status_reg;
    assign out_entry_count = out_count_reg;

endmodule

// ===== rtl/core/bmhq_ctrl.sv =====
// Controller of the heap queue: state machine that sequences sift-up and
// sift-down over the datapath. Depends on bmhq_pkg.
module bmhq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bmhq_pkg::sts_t sts,
    output bmhq_pkg::cmd_t ctl
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_UP_RD     = 4'd2;
    localparam logic [3:0] S_UP_CMP    = 4'd3;
    localparam logic [3:0] S_RD_ROOT   = 4'd4;
    localparam logic [3:0] S_RD_LAST   = 4'd5;
    localparam logic [3:0] S_TAKE_LAST = 4'd6;
    localparam logic [3:0] S_DN_RDL    = 4'd7;
    localparam logic [3:0] S_DN_RDR    = 4'd8;
    localparam logic [3:0] S_DN_RC     = 4'd9;
    localparam logic [3:0] S_DN_MOVE   = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = bmhq_pkg::RD_ROOT;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!sts.status_ok)
                begin
                    state_next = S_DONE;
                end
                else if (sts.is_insert)
                begin
                    state_next = sts.pos_zero ? S_DONE : S_UP_RD;
                end
                else
                begin
                    state_next = S_RD_ROOT;
                end
            end
            S_UP_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = bmhq_pkg::RD_PARENT;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (sts.key_gt_rdata)
                begin
                    ctl.move_up = 1'b1;
                    state_next  = sts.parent_zero ? S_DONE : S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_ROOT:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = bmhq_pkg::RD_ROOT;
                state_next = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = bmhq_pkg::RD_LAST;
                ctl.take_root = 1'b1;
                state_next    = S_TAKE_LAST;
            end
            S_TAKE_LAST:
            begin
                ctl.take_last = 1'b1;
                state_next    = sts.count_zero ? S_DONE : S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (sts.lc_valid)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = bmhq_pkg::RD_LEFT;
                    state_next = S_DN_RDR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_RDR:
            begin
                ctl.take_left = 1'b1;
                if (sts.rc_valid)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = bmhq_pkg::RD_RIGHT;
                    state_next = S_DN_RC;
                end
                else
                begin
                    state_next = S_DN_MOVE;
                end
            end
            S_DN_RC:
            begin
                // tie goes to the left child
                ctl.take_right = sts.right_gt_child;
                state_next     = S_DN_MOVE;
            end
            S_DN_MOVE:
            begin
                if (sts.child_gt_key)
                begin
                    ctl.move_down = 1'b1;
                    state_next    = S_DN_RDL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the response register is free
                if (sts.slot_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue: controller plus datapath.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if, bmhq_ctrl, bmhq_dp.
//
// Usage:
//   cmd carries one item per handshake: opcode (insert or extract maximum)
//   and a signed 32-bit value. rsp returns exactly one item per request:
//   max_value (extracted key, else 0), status (ok, empty, full) and
//   entry_count after the operation. An item moves when valid and ready
//   are both high at a rising clock edge.
//   One request is worked at a time; cmd.ready is high only while idle.
//   A full insert or an empty extract goes straight to the response. An
//   insert sifts up with a parent read and compare per level, at most
//   log2(CAPACITY) parent compares; an extract reads the root and the last
//   entry, then sifts down with a left and a right child read and a move per
//   level. All reads share the single read port of the heap RAM. cmd.ready
//   rises in the same cycle as rsp.valid, so the next item can be taken then.
//   The response sits in an output register; a new request is accepted
//   while it waits, works through and holds in its last state until the
//   receiver takes the earlier item.
//   Reset empties the queue and drops any pending response; heap contents
//   are not cleared.
module binary_max_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmhq_in_if.sink     cmd,
    bmhq_out_if.source  rsp
);

    bmhq_pkg::cmd_t ctl;
    bmhq_pkg::sts_t dp_sts;

    bmhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (dp_sts),
        .ctl      (ctl)
    );

    bmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (dp_sts),
        .in_opcode       (cmd.opcode),
        .in_value        (cmd.value),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_max_value   (rsp.max_value),
        .out_status      (rsp.status),
        .out_entry_count (rsp.entry_count)
    );

endmodule

// ===== rtl/core/bmhq_checker.sv =====
// Port-level checker for the heap queue, bound to the top level.
// Depends on bmhq_pkg and the macros header.
`include "binary_max_heap_queue_macros.svh"

module bmhq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [bmhq_pkg::KEY_W-1:0] rsp_max_value,
    input logic [bmhq_pkg::STATUS_W-1:0]     rsp_status,
    input logic [bmhq_pkg::COUNT_W-1:0]      rsp_entry_count
);

    localparam int ITEM_W = bmhq_pkg::KEY_W + bmhq_pkg::STATUS_W + bmhq_pkg::COUNT_W;

    logic              rsp_stall;
    logic              rsp_empty;
    logic              rsp_full;
    logic              rsp_count_zero;
    logic              rsp_max_zero;
    logic [ITEM_W-1:0] rsp_item;

    assign rsp_stall      = rsp_valid && !rsp_ready;
    assign rsp_empty      = rsp_valid && (rsp_status == bmhq_pkg::ST_EMPTY);
    assign rsp_full       = rsp_valid && (rsp_status == bmhq_pkg::ST_FULL);
    assign rsp_count_zero = (rsp_entry_count == '0);
    assign rsp_max_zero   = (rsp_max_value == '0);
    assign rsp_item       = {rsp_max_value, rsp_status, rsp_entry_count};

    `BMHQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid, "rsp item dropped in stall")
    `BMHQ_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(rsp_item), "rsp item changed")
    `BMHQ_ASSERT_NOW(a_empty_res, clk, rst_n, rsp_empty, rsp_count_zero && rsp_max_zero, "bad empty")
    `BMHQ_ASSERT_NOW(a_full_res, clk, rst_n, rsp_full, !rsp_count_zero && rsp_max_zero, "bad full")
    `BMHQ_ASSERT_NEXT(a_one_at_once, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "item taken busy")

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_max_value   (rsp.max_value),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
);
